>>> design/smwl_pkg.sv
// Package for the sorted merge with limit block.
// Holds the row and command types, register codes and the key order function.
// Used by the interfaces, front, back and top level; depends on nothing.
package smwl_pkg;

  localparam int KEY_W      = 64;
  localparam int TAG_W      = 32;
  localparam int ACT_W      = 2;
  localparam int LIMIT_W    = 7;
  localparam int MASK_W     = 3;
  localparam int NUM_KEYS   = 3;
  localparam int TOTAL_W    = 7;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [ACT_W-1:0] ACT_LOAD_LEFT  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD_RIGHT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_MERGE      = 2'd2;

  localparam logic REG_ROW_LIMIT = 1'b0;
  localparam logic REG_DESC_MASK = 1'b1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  typedef struct packed {
    logic signed [KEY_W-1:0] key_first;
    logic signed [KEY_W-1:0] key_second;
    logic signed [KEY_W-1:0] key_third;
    logic [TAG_W-1:0]        tag;
  } row_t;

  typedef struct packed {
    logic is_merge;
    logic to_right;
    row_t row;
  } cmd_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] row_limit;
    logic [MASK_W-1:0]  descending_mask;
  } cfg_t;

  // True when the right row must be emitted before the left row.
  function automatic logic right_first(row_t r, row_t l, logic [MASK_W-1:0] desc,
                                       int unsigned ncols);
    logic signed [KEY_W-1:0] rk [NUM_KEYS];
    logic signed [KEY_W-1:0] lk [NUM_KEYS];
    logic found;
    logic res;
    rk[0] = r.key_first;
    rk[1] = r.key_second;
    rk[2] = r.key_third;
    lk[0] = l.key_first;
    lk[1] = l.key_second;
    lk[2] = l.key_third;
    found = 1'b0;
    res   = 1'b0;
    for (int c = 0; c < NUM_KEYS; c++) begin
      if (!found && (c < ncols) && (rk[c] != lk[c])) begin
        found = 1'b1;
        res   = (rk[c] < lk[c]) ^ desc[c];
      end
    end
    return res;
  endfunction

endpackage

>>> design/smwl_ifs.sv
// Handshake interfaces for the input and result channels of the merge block.
// Each carries valid, ready and one word of payload; depends on smwl_pkg.
interface smwl_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [smwl_pkg::ACT_W-1:0]            action;
  logic signed [smwl_pkg::KEY_W-1:0]     key_first;
  logic signed [smwl_pkg::KEY_W-1:0]     key_second;
  logic signed [smwl_pkg::KEY_W-1:0]     key_third;
  logic [smwl_pkg::TAG_W-1:0]            row_tag;

  modport source (output valid, action, key_first, key_second, key_third, row_tag,
                  input ready);
  modport sink (input valid, action, key_first, key_second, key_third, row_tag,
                output ready);
endinterface

interface smwl_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [smwl_pkg::KEY_W-1:0]     out_key_first;
  logic signed [smwl_pkg::KEY_W-1:0]     out_key_second;
  logic signed [smwl_pkg::KEY_W-1:0]     out_key_third;
  logic [smwl_pkg::TAG_W-1:0]            out_tag;
  logic                                  from_right;
  logic                                  last;

  modport source (output valid, out_key_first, out_key_second, out_key_third, out_tag,
                  from_right, last, input ready);
  modport sink (input valid, out_key_first, out_key_second, out_key_third, out_tag,
                from_right, last, output ready);
endinterface

>>> design/sorted_merge_with_limit.sv
// Top level of the sorted merge with limit block: configuration registers,
// the front end queue and the back end merge engine.
// Depends on smwl_pkg, smwl_ifs, smwl_front and smwl_back.
//
// Usage: words arrive on in_if. Action 0 loads a row into the left store,
// action 1 into the right store, action 2 merges both stores; action 3 is
// dropped. Loads into a full store are dropped. A merge sends the rows in
// merged order on out_if, at most the row limit unless one store is
// empty, with last set on the final row, and then empties both stores.
// A merge reads the heads of both stores, then emits one row per cycle
// while out_if is ready; each store has a single registered read port,
// and the first row passes through it and then the output register. A
// two-word queue lets the input keep accepting while a merge drains.
// When out_if stalls the output register holds its row and the merge
// waits; the queue then fills and in_if ready falls. The user must write
// the registers over the APB port only while the block is idle; the
// block does not enforce this. Synchronous reset empties both stores
// and the queue and sets the row limit to 64 and descending_mask to 0.
module sorted_merge_with_limit #(
  parameter int LIST_DEPTH = 32,
  parameter int SORT_KEYS  = 3
) (
  input  logic                               clk,
  input  logic                               rst_n,
  smwl_in_if.sink                            in_if,
  smwl_out_if.source                         out_if,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [smwl_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [smwl_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [smwl_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import smwl_pkg::*;

  cfg_t cfg_r;
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;
  logic cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_limit       <= LIMIT_RESET;
      cfg_r.descending_mask <= '0;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_ROW_LIMIT: cfg_r.row_limit       <= pwdata[LIMIT_W-1:0];
        REG_DESC_MASK: cfg_r.descending_mask <= pwdata[MASK_W-1:0];
        default:       cfg_r                 <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ROW_LIMIT: prdata = CFG_DATA_W'(cfg_r.row_limit);
      REG_DESC_MASK: prdata = CFG_DATA_W'(cfg_r.descending_mask);
      default:       prdata = '0;
    endcase
  end

  smwl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  smwl_back #(
    .LIST_DEPTH (LIST_DEPTH),
    .SORT_KEYS  (SORT_KEYS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cfg       (cfg_r),
    .out_if    (out_if)
  );

endmodule

>>> design/smwl_front.sv
// Front end of the merge block: accepts input words, decodes the action and
// queues load and merge commands in a two-entry queue for the back end.
// Depends on smwl_pkg and smwl_in_if.
module smwl_front (
  input  logic           clk,
  input  logic           rst_n,
  smwl_in_if.sink        in_if,
  output smwl_pkg::cmd_t cmd,
  output logic           cmd_valid,
  input  logic           cmd_ready
);
  import smwl_pkg::*;

  cmd_t       q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r;
  logic       known;
  logic       push;
  logic       pop;
  cmd_t       in_cmd;

  assign in_if.ready = (fill_r != 2'd2);

  always_comb begin
    unique case (in_if.action) inside
      ACT_LOAD_LEFT, ACT_LOAD_RIGHT, ACT_MERGE: known = 1'b1;
      default:                                  known = 1'b0;
    endcase
  end

  assign in_cmd.is_merge       = (in_if.action == ACT_MERGE);
  assign in_cmd.to_right       = (in_if.action == ACT_LOAD_RIGHT);
  assign in_cmd.row.key_first  = in_if.key_first;
  assign in_cmd.row.key_second = in_if.key_second;
  assign in_cmd.row.key_third  = in_if.key_third;
  assign in_cmd.row.tag        = in_if.row_tag;

  assign push      = in_if.valid && in_if.ready && known;
  assign cmd_valid = (fill_r != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      fill_r <= fill_r + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> design/smwl_back.sv
// Back end of the merge block: the left and right row stores, their counts,
// and the merge sequencer that drives the registered result channel.
// Depends on smwl_pkg and smwl_out_if.
module smwl_back #(
  parameter int LIST_DEPTH = 32,
  parameter int SORT_KEYS  = 3
) (
  input  logic           clk,
  input  logic           rst_n,
  input  smwl_pkg::cmd_t cmd,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  smwl_pkg::cfg_t cfg,
  smwl_out_if.source     out_if
);
  import smwl_pkg::*;

  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  row_t lmem [LIST_DEPTH];
  row_t rmem [LIST_DEPTH];
  row_t lrd_r;
  row_t rrd_r;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   lcnt_r, lcnt_nxt;
  logic [CNT_W-1:0]   rcnt_r, rcnt_nxt;
  logic [CNT_W-1:0]   mlcnt_r, mlcnt_nxt;
  logic [CNT_W-1:0]   mrcnt_r, mrcnt_nxt;
  logic [CNT_W-1:0]   li_r, li_nxt;
  logic [CNT_W-1:0]   ri_r, ri_nxt;
  logic [TOTAL_W-1:0] k_r, k_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               out_valid_r, out_valid_nxt;
  row_t               out_row_r, out_row_nxt;
  logic               out_right_r, out_right_nxt;
  logic               out_last_r, out_last_nxt;

  logic               can_go;
  logic               take_right;
  logic [TOTAL_W-1:0] sum;
  logic [TOTAL_W-1:0] merge_total;
  logic               lwe;
  logic               rwe;

  assign cmd_ready = (state_r == ST_IDLE);
  assign can_go    = !out_valid_r || out_if.ready;
  assign sum       = TOTAL_W'(lcnt_r) + TOTAL_W'(rcnt_r);

  always_comb begin
    if (cfg.row_limit == '0) begin
      merge_total = '0;
    end else if ((lcnt_r == '0) || (rcnt_r == '0)) begin
      merge_total = sum;
    end else if (TOTAL_W'(cfg.row_limit) < sum) begin
      merge_total = TOTAL_W'(cfg.row_limit);
    end else begin
      merge_total = sum;
    end
  end

  always_comb begin
    if (li_r == mlcnt_r) begin
      take_right = 1'b1;
    end else if (ri_r == mrcnt_r) begin
      take_right = 1'b0;
    end else begin
      take_right = right_first(rrd_r, lrd_r, cfg.descending_mask, SORT_KEYS);
    end
  end

  assign lwe = (state_r == ST_IDLE) && cmd_valid && !cmd.is_merge && !cmd.to_right &&
               (lcnt_r < CNT_W'(LIST_DEPTH));
  assign rwe = (state_r == ST_IDLE) && cmd_valid && !cmd.is_merge && cmd.to_right &&
               (rcnt_r < CNT_W'(LIST_DEPTH));

  always_comb begin
    state_nxt     = state_r;
    lcnt_nxt      = lcnt_r;
    rcnt_nxt      = rcnt_r;
    mlcnt_nxt     = mlcnt_r;
    mrcnt_nxt     = mrcnt_r;
    li_nxt        = li_r;
    ri_nxt        = ri_r;
    k_nxt         = k_r;
    total_nxt     = total_r;
    out_row_nxt   = out_row_r;
    out_right_nxt = out_right_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.is_merge) begin
            mlcnt_nxt = lcnt_r;
            mrcnt_nxt = rcnt_r;
            lcnt_nxt  = '0;
            rcnt_nxt  = '0;
            li_nxt    = '0;
            ri_nxt    = '0;
            k_nxt     = '0;
            total_nxt = merge_total;
            if (merge_total != '0) begin
              state_nxt = ST_EMIT;
            end
          end else begin
            if (lwe) begin
              lcnt_nxt = lcnt_r + CNT_W'(1);
            end
            if (rwe) begin
              rcnt_nxt = rcnt_r + CNT_W'(1);
            end
          end
        end
      end
      ST_EMIT: begin
        if (can_go) begin
          out_valid_nxt = 1'b1;
          out_right_nxt = take_right;
          out_row_nxt   = take_right ? rrd_r : lrd_r;
          out_last_nxt  = (k_r == total_r - TOTAL_W'(1));
          k_nxt         = k_r + TOTAL_W'(1);
          if (take_right) begin
            ri_nxt = ri_r + CNT_W'(1);
          end else begin
            li_nxt = li_r + CNT_W'(1);
          end
          if (k_r == total_r - TOTAL_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (lwe) begin
      lmem[lcnt_r[ADDR_W-1:0]] <= cmd.row;
    end
    if (rwe) begin
      rmem[rcnt_r[ADDR_W-1:0]] <= cmd.row;
    end
    lrd_r <= lmem[li_nxt[ADDR_W-1:0]];
    rrd_r <= rmem[ri_nxt[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lcnt_r      <= '0;
      rcnt_r      <= '0;
      mlcnt_r     <= '0;
      mrcnt_r     <= '0;
      li_r        <= '0;
      ri_r        <= '0;
      k_r         <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lcnt_r      <= lcnt_nxt;
      rcnt_r      <= rcnt_nxt;
      mlcnt_r     <= mlcnt_nxt;
      mrcnt_r     <= mrcnt_nxt;
      li_r        <= li_nxt;
      ri_r        <= ri_nxt;
      k_r         <= k_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_row_r   <= out_row_nxt;
    out_right_r <= out_right_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.out_key_first  = out_row_r.key_first;
  assign out_if.out_key_second = out_row_r.key_second;
  assign out_if.out_key_third  = out_row_r.key_third;
  assign out_if.out_tag        = out_row_r.tag;
  assign out_if.from_right     = out_right_r;
  assign out_if.last           = out_last_r;

  a_heads_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> ((li_r <= mlcnt_r) && (ri_r <= mrcnt_r)))
    else $error("merge head index passed the row count");

  a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (lcnt_r <= CNT_W'(LIST_DEPTH)) && (rcnt_r <= CNT_W'(LIST_DEPTH)))
    else $error("store count exceeds the store depth");

  a_emit_below_total: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (k_r < total_r))
    else $error("emitted more rows than the merge allows");

  a_emit_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EMIT) && can_go) |=> out_valid_r)
    else $error("emitted row did not reach the output register");

endmodule

>>> sim/merge_checker.sv
`timescale 1ns / 100ps
// Checker for the sorted merge block: watches the row, result and APB ports,
// keeps its own copy of the stores and registers, and compares every result word.
// Depends on smwl_pkg and the channel interfaces in smwl_ifs.
module merge_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  smwl_in_if                              in_ch,
  smwl_out_if                             out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [smwl_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [smwl_pkg::CFG_DATA_W-1:0] pwdata,
  output int                              mismatches,
  output int                              rows_outstanding
);
  import smwl_pkg::*;

  localparam int DEPTH = 32;

  typedef struct packed {
    row_t row;
    logic from_right;
    logic last;
  } merged_row_t;

  row_t               left_rows [DEPTH];
  row_t               right_rows [DEPTH];
  int unsigned        left_n;
  int unsigned        right_n;
  logic [LIMIT_W-1:0] limit_reg;
  logic [MASK_W-1:0]  desc_mask;
  merged_row_t        pending_rows [$];
  merged_row_t        want;
  row_t               word_row;

  function automatic logic signed [KEY_W-1:0] key_at(row_t r, int col);
    case (col)
      0: return r.key_first;
      1: return r.key_second;
      default: return r.key_third;
    endcase
  endfunction

  function automatic bit right_goes_first(row_t r, row_t l);
    for (int c = 0; c < NUM_KEYS; c++) begin
      if (key_at(r, c) != key_at(l, c)) begin
        return desc_mask[c] ? (key_at(r, c) > key_at(l, c)) : (key_at(r, c) < key_at(l, c));
      end
    end
    return 1'b0;
  endfunction

  task automatic store_row(input bit to_right, input row_t r);
    if (to_right) begin
      if (right_n < DEPTH) begin
        right_rows[right_n] = r;
        right_n++;
      end
    end else begin
      if (left_n < DEPTH) begin
        left_rows[left_n] = r;
        left_n++;
      end
    end
  endtask

  task automatic predict_merge();
    int unsigned li;
    int unsigned ri;
    int unsigned emitted;
    int unsigned cap;
    merged_row_t m;
    li = 0;
    ri = 0;
    emitted = 0;
    if (limit_reg == 0) begin
      cap = 0;
    end else if (left_n == 0 || right_n == 0) begin
      cap = left_n + right_n;
    end else begin
      cap = limit_reg;
    end
    while (emitted < cap && (li < left_n || ri < right_n)) begin
      m.last = 1'b0;
      if (li == left_n || (ri < right_n && right_goes_first(right_rows[ri], left_rows[li]))) begin
        m.row = right_rows[ri];
        m.from_right = 1'b1;
        ri++;
      end else begin
        m.row = left_rows[li];
        m.from_right = 1'b0;
        li++;
      end
      pending_rows = {pending_rows, m};
      emitted++;
    end
    if (emitted > 0) begin
      pending_rows[pending_rows.size() - 1].last = 1'b1;
    end
    left_n = 0;
    right_n = 0;
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_val,
                             input logic [63:0] got_val);
    if (exp_val !== got_val) begin
      $error("%s: expected %h, got %h", name, exp_val, got_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      left_n = 0;
      right_n = 0;
      limit_reg = LIMIT_RESET;
      desc_mask = '0;
      pending_rows.delete();
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if ((paddr >> 2) == REG_ROW_LIMIT) begin
          limit_reg = pwdata[LIMIT_W-1:0];
        end else if ((paddr >> 2) == REG_DESC_MASK) begin
          desc_mask = pwdata[MASK_W-1:0];
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_rows.size() == 0) begin
          $error("result word with no row expected: tag %h", out_ch.out_tag);
          mismatches++;
        end else begin
          want = pending_rows.pop_front();
          check_field("out_key_first", want.row.key_first, out_ch.out_key_first);
          check_field("out_key_second", want.row.key_second, out_ch.out_key_second);
          check_field("out_key_third", want.row.key_third, out_ch.out_key_third);
          check_field("out_tag", 64'(want.row.tag), 64'(out_ch.out_tag));
          check_field("from_right", 64'(want.from_right), 64'(out_ch.from_right));
          check_field("last", 64'(want.last), 64'(out_ch.last));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        word_row = '{in_ch.key_first, in_ch.key_second, in_ch.key_third, in_ch.row_tag};
        case (in_ch.action)
          ACT_LOAD_LEFT: begin
            store_row(1'b0, word_row);
          end
          ACT_LOAD_RIGHT: begin
            store_row(1'b1, word_row);
          end
          ACT_MERGE: begin
            predict_merge();
          end
          default: begin
          end
        endcase
      end
    end
    rows_outstanding = pending_rows.size();
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// Top of the sorted merge testbench: clock, reset, row and merge stimulus,
// APB register writes, result-side stalls and the verdict.
// Depends on smwl_pkg, smwl_ifs, sorted_merge_with_limit and merge_checker.
module testbench;
  import smwl_pkg::*;

  localparam logic [ACT_W-1:0]      ACT_IGNORED    = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] LIMIT_ADDR     = {REG_ROW_LIMIT, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] MASK_ADDR      = {REG_DESC_MASK, 2'b00};
  localparam int                    DEPTH          = 32;
  localparam int                    ITEM_TARGET    = 480;
  localparam int                    CALM_ITEMS     = 80;
  localparam int                    LONG_HOLD      = 400;
  localparam int                    SETTLE_CYCLES  = 12;
  localparam int                    WATCHDOG_LIMIT = 3000;
  localparam longint                KEY_MAX        = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint                KEY_MIN        = 64'sh8000_0000_0000_0000;

  typedef row_t row_q_t [$];

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    mismatches;
  int                    rows_outstanding;
  int                    items_sent;
  int                    quiet_cycles = 0;
  bit                    gaps_on;
  bit                    stalls_on;
  bit                    hold_req;
  logic [MASK_W-1:0]     cur_mask;
  longint                key_base [3];

  smwl_in_if  in_ch ();
  smwl_out_if out_ch ();

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  sorted_merge_with_limit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  merge_checker merge_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ch            (in_ch),
    .out_ch           (out_ch),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .mismatches       (mismatches),
    .rows_outstanding (rows_outstanding)
  );

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int unsigned left;
    logic        level;
    out_ch.ready = 1'b0;
    left = 0;
    level = 1'b1;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        level = 1'b0;
        left = LONG_HOLD;
      end else if (left == 0) begin
        if (stalls_on && $urandom_range(0, 2) == 0) begin
          level = 1'b0;
          left = $urandom_range(1, 9);
        end else begin
          level = 1'b1;
          left = $urandom_range(1, 12);
        end
      end
      out_ch.ready <= level;
      left--;
    end
  end

  function automatic row_t random_row();
    row_t r;
    r.key_first = {$urandom, $urandom};
    r.key_second = {$urandom, $urandom};
    r.key_third = {$urandom, $urandom};
    r.tag = $urandom;
    return r;
  endfunction

  // Ordered lists step one key column in the sort direction or repeat a row,
  // and reset later columns near a shared base, so both sides collide often.
  function automatic row_q_t make_list(int n, bit ordered);
    row_q_t rows;
    row_t   r;
    longint k [3];
    longint step;
    int     col;
    for (int i = 0; i < n; i++) begin
      if (!ordered) begin
        r = random_row();
      end else begin
        col = (i == 0) ? -1 : $urandom_range(0, 3);
        for (int j = 0; j < 3; j++) begin
          step = longint'($urandom_range(1, 4));
          if (col < 0 || j > col) begin
            k[j] = key_base[j] + longint'($urandom_range(0, 6)) - 3;
          end else if (j == col) begin
            k[j] = cur_mask[j] ? k[j] - step : k[j] + step;
          end
        end
        r = '{k[0], k[1], k[2], $urandom};
      end
      rows = {rows, r};
    end
    return rows;
  endfunction

  function automatic int pick_count();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return $urandom_range(DEPTH + 1, DEPTH + 4);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  task automatic push_word(input logic [ACT_W-1:0] act, input row_t r);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.key_first <= r.key_first;
    in_ch.key_second <= r.key_second;
    in_ch.key_third <= r.key_third;
    in_ch.row_tag <= r.tag;
    do @(posedge clk); while (!in_ch.ready);
    if (act != ACT_IGNORED) begin
      items_sent++;
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (rows_outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input int limit, input int mask);
    write_reg(LIMIT_ADDR, ($urandom & ~32'h0000_007F) | 32'(limit));
    write_reg(MASK_ADDR, ($urandom & ~32'h0000_0007) | 32'(mask));
    cur_mask = mask[MASK_W-1:0];
  endtask

  task automatic run_batch(input int nl, input int nr, input bit ordered,
                           input bit hold_at_merge);
    row_q_t lq;
    row_q_t rq;
    for (int j = 0; j < 3; j++) begin
      case ($urandom_range(0, 3))
        0: key_base[j] = 0;
        1: key_base[j] = KEY_MAX - 1000;
        2: key_base[j] = KEY_MIN + 1000;
        default: key_base[j] = longint'($urandom_range(0, 2000000)) - 1000000;
      endcase
    end
    lq = make_list(nl, ordered);
    rq = make_list(nr, ordered);
    while (lq.size() != 0 || rq.size() != 0) begin
      if ($urandom_range(0, 15) == 0) begin
        push_word(ACT_IGNORED, random_row());
      end
      if (rq.size() == 0 || (lq.size() != 0 && $urandom_range(0, 1) == 0)) begin
        push_word(ACT_LOAD_LEFT, lq.pop_front());
      end else begin
        push_word(ACT_LOAD_RIGHT, rq.pop_front());
      end
    end
    if (hold_at_merge) begin
      hold_req = 1'b1;
    end
    push_word(ACT_MERGE, random_row());
  endtask

  initial begin
    int phase;
    int phase_start;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_LOAD_LEFT;
    in_ch.key_first = '0;
    in_ch.key_second = '0;
    in_ch.key_third = '0;
    in_ch.row_tag = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    hold_req = 1'b0;
    items_sent = 0;
    cur_mask = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Full ties go left first; the third key alone decides one pair.
    push_word(ACT_LOAD_LEFT, '{KEY_MIN, KEY_MIN, KEY_MIN, 32'h0000_0000});
    push_word(ACT_LOAD_RIGHT, '{KEY_MIN, KEY_MIN, KEY_MIN, 32'h0000_0001});
    push_word(ACT_LOAD_LEFT, '{-64'sd1, 64'sd0, 64'sd5, 32'hFFFF_FFFF});
    push_word(ACT_LOAD_RIGHT, '{-64'sd1, 64'sd0, 64'sd4, 32'h5555_5555});
    push_word(ACT_LOAD_RIGHT, '{64'sd0, KEY_MIN, KEY_MAX, 32'hAAAA_AAAA});
    push_word(ACT_IGNORED, '{-64'sd1, -64'sd1, -64'sd1, 32'hFFFF_FFFF});
    push_word(ACT_LOAD_LEFT, '{KEY_MAX, KEY_MAX, KEY_MAX, 32'h8000_0000});
    push_word(ACT_LOAD_RIGHT, '{KEY_MAX, KEY_MAX, KEY_MAX, 32'h7FFF_FFFF});
    push_word(ACT_MERGE, '{64'sd0, 64'sd0, 64'sd0, 32'h0});
    push_word(ACT_MERGE, random_row());
    repeat (3) push_word(ACT_LOAD_RIGHT, random_row());
    push_word(ACT_MERGE, random_row());
    repeat (2) push_word(ACT_LOAD_LEFT, random_row());
    push_word(ACT_MERGE, random_row());
    wait_drained();

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0: set_config(0, $urandom_range(0, 7));
        1: set_config(1, 0);
        2: set_config(64, 7);
        3: set_config($urandom_range(2, 8), 5);
        default: begin
          case ($urandom_range(0, 4))
            0: set_config($urandom_range(1, 4), $urandom_range(0, 7));
            1: set_config($urandom_range(5, 16), $urandom_range(0, 7));
            2: set_config(64, $urandom_range(0, 7));
            default: set_config($urandom_range(0, 64), $urandom_range(0, 7));
          endcase
        end
      endcase
      if (phase == 2) begin
        // The result side holds off while a second batch keeps arriving.
        run_batch(30, 30, 1'b1, 1'b1);
        run_batch(20, 20, 1'b1, 1'b0);
      end
      phase_start = items_sent;
      while (items_sent - phase_start < 60 && items_sent < ITEM_TARGET) begin
        if (items_sent >= ITEM_TARGET - CALM_ITEMS) begin
          gaps_on = 1'b0;
          stalls_on = 1'b0;
        end
        run_batch(pick_count(), pick_count(), $urandom_range(0, 9) != 0, 1'b0);
        if ($urandom_range(0, 3) == 0) begin
          wait_drained();
        end
      end
      wait_drained();
      phase++;
    end

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sorted_merge_with_limit.f
design/smwl_pkg.sv
design/smwl_ifs.sv
design/smwl_front.sv
design/smwl_back.sv
design/sorted_merge_with_limit.sv
sim/merge_checker.sv
sim/testbench.sv
